/* sv/yolo_detection_decode_macros.svh */
// Assertion macros shared by the detection decoder RTL.
// Depends on nothing; users must provide clk_i and rst_ni in scope.
`ifndef YOLO_DETECTION_DECODE_MACROS_SVH
`define YOLO_DETECTION_DECODE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define YDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define YDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ydd_pkg.sv */
// Package for the detection decoder: sizes, positions, register indexes and types.
// Depends on nothing; imported by every module of the block.
package ydd_pkg;

  localparam int NUM_CLASSES     = 80;
  localparam int MAX_ANCHORS     = 65536;
  localparam int OBJ_POS         = 4;
  localparam int FIRST_CLASS_POS = 5;
  localparam int LAST_POS        = FIRST_CLASS_POS + NUM_CLASSES;

  localparam int POS_W    = 7;
  localparam int ANCHOR_W = 16;
  localparam int DIM_W    = 14;
  localparam int THR_W    = 17;
  localparam int EDGE_W   = 30;
  localparam int SCORE_W  = 17;
  localparam int CLASS_W  = 7;
  localparam int DIVD_W   = 49;
  localparam int DIVS_W   = DIM_W + 1;

  // Configuration register indexes.
  localparam logic [2:0] REG_CONF_THR  = 3'd0;
  localparam logic [2:0] REG_MULTI     = 3'd1;
  localparam logic [2:0] REG_NET_H     = 3'd2;
  localparam logic [2:0] REG_NET_W     = 3'd3;
  localparam logic [2:0] REG_IMG_H     = 3'd4;
  localparam logic [2:0] REG_IMG_W     = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } ydd_div_status_t;

endpackage

/* sv/ydd_divider.sv */
// Radix-2 restoring divider, one quotient bit per cycle, shared by all box edges.
// Depends on ydd_pkg for operand widths and the status struct.
module ydd_divider
  import ydd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIVD_W-1:0]    dividend_i,
  input  logic [DIVS_W-1:0]    divisor_i,
  output logic [DIVD_W-1:0]    quotient_o,
  output ydd_div_status_t      status_o
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [DIVS_W-1:0] div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DIVS_W:0]   trial;
  logic              take;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign take  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d = take ? DIVS_W'(trial - {1'b0, div_q}) : trial[DIVS_W-1:0];
    quo_d = {quo_q[DIVD_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign status_o   = '{busy: busy_q, done: done_q};

endmodule

/* sv/yolo_detection_decode.sv */
// Detection-row decoder: streams prediction values in, emits clipped boxes in image space.
// Depends on ydd_pkg, ydd_divider and yolo_detection_decode_macros.svh.
//
// Prediction rows arrive one signed Q16.16 value per request: centre x, centre y, width,
// height, objectness and then one score per class, with tlast on the last value of a row
// and tuser on the row end of the last row of an image. Each confidence is the exact
// product of objectness and a class score, compared strictly against the confidence
// threshold register. In multi-label mode a passing class emits a box as its score
// arrives; in single-label mode the first maximal class is tested when the row ends. Box,
// objectness and non-candidate values are taken in the idle state; a class value that is
// a candidate passes through the multiply and test states and back to idle when it fails
// the threshold. A passing box is mapped edge by edge through one shared bit-serial
// divider. Each edge runs through numerator set-up, launch, one quotient step per dividend
// bit and the hand-back, or only set-up and launch when its numerator is not positive, and
// an emitting request holds off the next request until its box is loaded into the output
// register. The letterbox scale and padding are registered and recomputed continuously from
// the registers via registered cross products. Finished boxes sit in an output register,
// so the next request is taken while a box waits for the consumer.
`include "yolo_detection_decode_macros.svh"

module yolo_detection_decode
  import ydd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input stream; tdata: value[31:0].
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [31:0]   s_axis_tdata_i,
  input  logic          s_axis_tlast_i,   // row end
  input  logic          s_axis_tuser_i,   // image end
  // Output stream; tdata: left[29:0], top[59:30], right[89:60], bottom[119:90],
  // class_label[126:120], score[143:127], anchor_index[159:144].
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [159:0]  m_axis_tdata_o,
  // Configuration port.
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_TEST   = 3'd2;
  localparam logic [2:0] S_NUM    = 3'd3;
  localparam logic [2:0] S_LAUNCH = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // ---------------------------------------------------------------- registers
  logic [THR_W-1:0] conf_thr_q;
  logic             multi_q;
  logic [DIM_W-1:0] net_h_q, net_w_q, img_h_q, img_w_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q <= THR_W'(16384);
      multi_q    <= 1'b1;
      net_h_q    <= DIM_W'(640);
      net_w_q    <= DIM_W'(640);
      img_h_q    <= DIM_W'(640);
      img_w_q    <= DIM_W'(640);
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_CONF_THR: conf_thr_q <= pwdata[THR_W-1:0];
        REG_MULTI:    multi_q    <= pwdata[0];
        REG_NET_H:    net_h_q    <= pwdata[DIM_W-1:0];
        REG_NET_W:    net_w_q    <= pwdata[DIM_W-1:0];
        REG_IMG_H:    img_h_q    <= pwdata[DIM_W-1:0];
        REG_IMG_W:    img_w_q    <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CONF_THR: prdata = 32'(conf_thr_q);
      REG_MULTI:    prdata = 32'(multi_q);
      REG_NET_H:    prdata = 32'(net_h_q);
      REG_NET_W:    prdata = 32'(net_w_q);
      REG_IMG_H:    prdata = 32'(img_h_q);
      REG_IMG_W:    prdata = 32'(img_w_q);
      default:      prdata = '0;
    endcase
  end

  // ------------------------------------------------------------ letterbox
  // A size register holding zero counts as one. The chosen ratio sn/sd makes one
  // of the two paddings zero, and the other is the difference of the cross products.
  logic [DIM_W-1:0]   nh, nw, ih, iw;
  logic [2*DIM_W-1:0] p_hw_q, p_wh_q;
  logic [DIM_W-1:0]   sn_q, sd_q;
  logic [2*DIM_W-1:0] pad_v_q, pad_h_q;
  logic               by_height;

  assign nh = (net_h_q == '0) ? DIM_W'(1) : net_h_q;
  assign nw = (net_w_q == '0) ? DIM_W'(1) : net_w_q;
  assign ih = (img_h_q == '0) ? DIM_W'(1) : img_h_q;
  assign iw = (img_w_q == '0) ? DIM_W'(1) : img_w_q;
  assign by_height = p_hw_q <= p_wh_q;

  always_ff @(posedge clk_i) begin
    p_hw_q  <= nh * iw;
    p_wh_q  <= nw * ih;
    sn_q    <= by_height ? nh : nw;
    sd_q    <= by_height ? ih : iw;
    pad_v_q <= by_height ? '0 : p_hw_q - p_wh_q;
    pad_h_q <= by_height ? p_wh_q - p_hw_q : '0;
  end

  // --------------------------------------------------------------- row state
  logic [2:0]          state_q;
  logic [POS_W-1:0]    pos_q;
  logic [ANCHOR_W-1:0] anchor_q, anchor_out_q;
  logic signed [31:0]  box_q [4];
  logic signed [31:0]  obj_q, best_q, mul_b_q;
  logic [CLASS_W-1:0]  best_cls_q, label_q;
  logic signed [63:0]  prod_q;
  logic [SCORE_W-1:0]  score_q;
  logic [1:0]          edge_q;
  logic signed [49:0]  num_q;
  logic [EDGE_W-1:0]   edge_val_q [4];

  logic               in_acc, in_class, cand_multi, cand_single, new_best;
  logic signed [31:0] v;
  logic [CLASS_W-1:0] cls;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign v        = s_axis_tdata_i;
  assign in_class = (pos_q >= POS_W'(FIRST_CLASS_POS)) && (pos_q < POS_W'(LAST_POS));
  assign cls      = CLASS_W'(pos_q - POS_W'(FIRST_CLASS_POS));
  assign new_best = in_class && ((cls == '0) || (v > best_q));
  assign cand_multi  = multi_q & in_class;
  assign cand_single = ~multi_q & s_axis_tlast_i & (pos_q >= POS_W'(FIRST_CLASS_POS));

  // ------------------------------------------------------------ edge mapping
  logic signed [31:0] ctr, siz;
  logic signed [33:0] dbl;
  logic signed [49:0] num_d;
  logic [2*DIM_W-1:0] pad_sel;
  logic [DIM_W-1:0]   dim_sel;
  logic [EDGE_W-1:0]  limit, clipped;
  logic [DIVD_W-1:0]  quotient;
  ydd_div_status_t    div_st;
  logic               div_start, edge_store, out_load;
  logic [47:0]        sc_full;

  assign ctr     = edge_q[0] ? box_q[1] : box_q[0];
  assign siz     = edge_q[0] ? box_q[3] : box_q[2];
  assign dbl     = edge_q[1] ? (34'(ctr) <<< 1) + 34'(siz) : (34'(ctr) <<< 1) - 34'(siz);
  assign pad_sel = edge_q[0] ? pad_v_q : pad_h_q;
  assign num_d   = 50'(dbl) * 50'($signed({1'b0, sd_q})) - 50'({pad_sel, 16'd0});
  assign dim_sel = edge_q[0] ? ih : iw;
  assign limit   = {dim_sel, 16'd0};
  assign clipped = (quotient > DIVD_W'(limit)) ? limit : quotient[EDGE_W-1:0];

  assign div_start  = (state_q == S_LAUNCH) && (num_q > 0);
  assign edge_store = ((state_q == S_LAUNCH) && !(num_q > 0)) ||
                      ((state_q == S_DIV) && div_st.done);
  assign out_load   = (state_q == S_OUT) && (!m_axis_tvalid_o || m_axis_tready_i);
  assign sc_full    = prod_q[63:16];

  ydd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q[DIVD_W-1:0]),
    .divisor_i  ({sn_q, 1'b0}),
    .quotient_o (quotient),
    .status_o   (div_st)
  );

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      anchor_q   <= '0;
      best_q     <= '0;
      best_cls_q <= '0;
      edge_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (new_best) begin
              best_q     <= v;
              best_cls_q <= cls;
            end
            if (s_axis_tlast_i) begin
              pos_q <= '0;
              if (s_axis_tuser_i || anchor_q == ANCHOR_W'(MAX_ANCHORS - 1)) begin
                anchor_q <= '0;
              end else begin
                anchor_q <= anchor_q + 1'b1;
              end
            end else if (pos_q < POS_W'(LAST_POS)) begin
              pos_q <= pos_q + 1'b1;
            end
            if (cand_multi || cand_single) begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: state_q <= S_TEST;
        S_TEST: begin
          edge_q  <= '0;
          state_q <= (prod_q > $signed({15'd0, conf_thr_q, 32'd0} >>> 16)) ? S_NUM : S_IDLE;
        end
        S_NUM: state_q <= S_LAUNCH;
        S_LAUNCH: begin
          if (num_q > 0) begin
            state_q <= S_DIV;
          end else begin
            edge_q  <= edge_q + 1'b1;
            state_q <= (edge_q == 2'd3) ? S_OUT : S_NUM;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            edge_q  <= edge_q + 1'b1;
            state_q <= (edge_q == 2'd3) ? S_OUT : S_NUM;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (pos_q < POS_W'(OBJ_POS)) begin
        box_q[pos_q[1:0]] <= v;
      end else if (pos_q == POS_W'(OBJ_POS)) begin
        obj_q <= v;
      end
      mul_b_q      <= (cand_multi || new_best) ? v : best_q;
      label_q      <= (cand_multi || new_best) ? cls : best_cls_q;
      anchor_out_q <= anchor_q;
    end
    if (state_q == S_MUL) begin
      prod_q <= obj_q * mul_b_q;
    end
    if (state_q == S_TEST) begin
      score_q <= (sc_full > 48'd65536) ? SCORE_W'(65536) : sc_full[SCORE_W-1:0];
    end
    if (state_q == S_NUM) begin
      num_q <= num_d;
    end
    if (edge_store) begin
      edge_val_q[edge_q] <= (state_q == S_DIV) ? clipped : '0;
    end
  end

  // --------------------------------------------------------- output register
  logic         m_valid_q;
  logic [159:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {anchor_out_q, score_q, label_q,
                   edge_val_q[3], edge_val_q[2], edge_val_q[1], edge_val_q[0]};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // --------------------------------------------------------------- checks
  `YDD_ASSERT_NOW(a_div_only_in_div, div_st.busy, state_q == S_DIV, "divider busy outside S_DIV")
  `YDD_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= POS_W'(LAST_POS), "row position out of range")
  `YDD_ASSERT_NEXT(a_load_sets_valid, out_load, m_axis_tvalid_o && state_q == S_IDLE,
                   "box load did not present a result")

endmodule
